// ----- rtl/mrfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the mesh reflood frame parser.
// No dependencies; used by every module of the block.
package mrfp_pkg;

    // Frame limits
    localparam int MAX_FRAME_BYTES = 512;
    localparam int MIN_FRAME_BYTES = 5;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    // Command queue between parser and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // FNV-1a 32-bit constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Fixed header layout
    localparam logic [2:0] SIGNAL_SKIP    = 3'd2;
    localparam logic [2:0] TRANSPORT_SKIP = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_HASH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_FRAME_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_TEXT_TYPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOD_ROUTE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_ROUTE    = 3'd5;

    // Summary status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_CODE    = 3'd1;
    localparam logic [2:0] ST_NOT_GROUP   = 3'd2;
    localparam logic [2:0] ST_NO_PATH     = 3'd3;
    localparam logic [2:0] ST_PATH_OVERRUN = 3'd4;

    // Result kinds
    localparam logic KIND_HASH    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_CODE,
        PH_SIGNAL,
        PH_HEADER,
        PH_TSKIP,
        PH_PATHLEN,
        PH_PATH,
        PH_PAYLOAD,
        PH_DRAIN
    } phase_t;

    typedef struct packed {
        logic [7:0] own_node_hash;
        logic [5:0] hash_limit;
        logic [7:0] log_frame_code;
        logic [3:0] group_text_type;
        logic [1:0] transport_flood_route;
        logic [1:0] transport_direct_route;
    } cfg_t;

    // One classified byte handed from parser to back end
    typedef struct packed {
        logic       emit_hash;
        logic       payload;
        logic [7:0] data;
        logic       eof;
        logic [2:0] status;
        logic [5:0] hash_total;
        logic       own_seen;
    } cmd_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  path_hash;
        logic [5:0]  hash_total;
        logic [31:0] payload_digest;
        logic        own_in_path;
        logic [2:0]  status;
        logic        last_of_run;
    } res_t;

endpackage

// ----- rtl/mesh_reflood_frame_parser_unit.sv -----
`timescale 1ns / 1ps
// Top level of the mesh reflood frame parser: configuration registers and
// the front end, command queue and back end. Depends on mrfp_pkg.

// The unit takes one frame byte per cycle on the input channel while the
// command queue has room, and returns path hash entries as the path streams
// in, then one summary on the last byte of each frame. Hash entries are
// provisional: discard them when the summary that follows carries a nonzero
// status. A byte is classified in the cycle it is accepted and goes through
// a four-entry command queue to the back end, which folds one payload byte
// per cycle, unless a result ahead of it waits on the output, into the FNV-1a
// digest with a single 32x32 multiply and registers each result. A path byte
// that ends the frame yields two results, a hash entry and then the summary.
// A byte that makes a result is held in a queue entry, then in the result register.
// Configuration writes are always taken; write only while idle.
module mesh_reflood_frame_parser_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mrfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        frame_byte,
    input  logic                              end_of_frame,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              result_kind,
    output logic [7:0]                        path_hash,
    output logic [5:0]                        hash_total,
    output logic [31:0]                       payload_digest,
    output logic                              own_in_path,
    output logic [2:0]                        status,
    output logic                              last_of_run
);
    import mrfp_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  push_data;
    cmd_t  pop_data;
    res_t  res;
    logic  push_valid;
    logic  push_ready;
    logic  pop_valid;
    logic  pop;

    assign cfg_ready = 1'b1;

    // Write configuration registers; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_node_hash          <= 8'd0;
            cfg_reg.hash_limit             <= 6'd63;
            cfg_reg.log_frame_code         <= 8'd136;
            cfg_reg.group_text_type        <= 4'd5;
            cfg_reg.transport_flood_route  <= 2'd0;
            cfg_reg.transport_direct_route <= 2'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OWN_NODE_HASH:   cfg_reg.own_node_hash          <= cfg_data;
                REG_HASH_LIMIT:      cfg_reg.hash_limit             <= cfg_data[5:0];
                REG_LOG_FRAME_CODE:  cfg_reg.log_frame_code         <= cfg_data;
                REG_GROUP_TEXT_TYPE: cfg_reg.group_text_type        <= cfg_data[3:0];
                REG_FLOOD_ROUTE:     cfg_reg.transport_flood_route  <= cfg_data[1:0];
                REG_DIRECT_ROUTE:    cfg_reg.transport_direct_route <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    mrfp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    mrfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    mrfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .cmd       (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    // Break out the result fields
    assign result_kind    = res.result_kind;
    assign path_hash      = res.path_hash;
    assign hash_total     = res.hash_total;
    assign payload_digest = res.payload_digest;
    assign own_in_path    = res.own_in_path;
    assign status         = res.status;
    assign last_of_run    = res.last_of_run;

endmodule

// ----- rtl/mrfp_front.sv -----
`timescale 1ns / 1ps
// Parser front end: accepts frame bytes, tracks the header and path, and
// classifies each byte into a command for the back end. Uses mrfp_pkg.
module mrfp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  mrfp_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          frame_byte,
    input  logic                end_of_frame,
    output logic                push_valid,
    input  logic                push_ready,
    output mrfp_pkg::cmd_t      push_data
);
    import mrfp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [2:0]        skip_reg, skip_next;
    logic [2:0]        esize_reg, esize_next;
    logic [5:0]        hops_reg, hops_next;
    logic [5:0]        hop_idx_reg, hop_idx_next;
    logic [1:0]        bie_reg, bie_next;
    logic [5:0]        hashes_reg, hashes_next;
    logic              own_reg, own_next;
    logic [2:0]        err_reg, err_next;

    logic              accept;
    logic              emit_hash;
    logic [2:0]        skip_dec;
    logic [2:0]        bie_inc;
    logic [5:0]        hop_inc;
    logic [1:0]        route;
    logic [2:0]        status;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign route    = frame_byte[1:0];
    assign skip_dec = skip_reg - 3'd1;
    assign bie_inc  = {1'b0, bie_reg} + 3'd1;
    assign hop_inc  = hop_idx_reg + 6'd1;
    assign emit_hash = (phase_reg == PH_PATH) && (bie_reg == 2'd0)
                       && (hashes_reg < cfg.hash_limit);

    // Advance the parse state for the current byte
    always_comb
    begin
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        esize_next   = esize_reg;
        hops_next    = hops_reg;
        hop_idx_next = hop_idx_reg;
        bie_next     = bie_reg;
        hashes_next  = hashes_reg;
        own_next     = own_reg;
        err_next     = err_reg;
        pos_next     = (pos_reg < POS_W'(MAX_FRAME_BYTES)) ? pos_reg + 1'b1 : pos_reg;
        case (phase_reg)
            PH_CODE:
            begin
                if (frame_byte != cfg.log_frame_code)
                begin
                    err_next   = ST_BAD_CODE;
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    skip_next  = SIGNAL_SKIP;
                    phase_next = PH_SIGNAL;
                end
            end
            PH_SIGNAL:
            begin
                skip_next = skip_dec;
                if (skip_dec == 3'd0)
                    phase_next = PH_HEADER;
            end
            PH_HEADER:
            begin
                if (frame_byte[5:2] != cfg.group_text_type)
                begin
                    err_next   = ST_NOT_GROUP;
                    phase_next = PH_DRAIN;
                end
                else if (route == cfg.transport_flood_route ||
                         route == cfg.transport_direct_route)
                begin
                    skip_next  = TRANSPORT_SKIP;
                    phase_next = PH_TSKIP;
                end
                else
                begin
                    phase_next = PH_PATHLEN;
                end
            end
            PH_TSKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 3'd0)
                    phase_next = PH_PATHLEN;
            end
            PH_PATHLEN:
            begin
                esize_next   = {1'b0, frame_byte[7:6]} + 3'd1;
                hops_next    = frame_byte[5:0];
                hop_idx_next = 6'd0;
                bie_next     = 2'd0;
                phase_next   = (frame_byte[5:0] == 6'd0) ? PH_PAYLOAD : PH_PATH;
            end
            PH_PATH:
            begin
                if (emit_hash)
                begin
                    hashes_next = hashes_reg + 6'd1;
                    if (cfg.own_node_hash != 8'd0 && frame_byte == cfg.own_node_hash)
                        own_next = 1'b1;
                end
                if (bie_inc >= esize_reg)
                begin
                    bie_next     = 2'd0;
                    hop_idx_next = hop_inc;
                    if (hop_inc >= hops_reg)
                        phase_next = PH_PAYLOAD;
                end
                else
                begin
                    bie_next = bie_inc[1:0];
                end
            end
            default:
            begin
                // payload and drain bytes only advance the byte position
            end
        endcase
    end

    // Classify the byte and form the summary status
    always_comb
    begin
        if (pos_next < POS_W'(MIN_FRAME_BYTES))
            status = ST_BAD_CODE;
        else if (err_next != ST_OK)
            status = err_next;
        else if (phase_next == PH_PAYLOAD)
            status = ST_OK;
        else if (phase_next == PH_PATH)
            status = ST_PATH_OVERRUN;
        else
            status = ST_NO_PATH;

        push_data.emit_hash  = emit_hash;
        push_data.payload    = (phase_reg == PH_PAYLOAD);
        push_data.data       = frame_byte;
        push_data.eof        = end_of_frame;
        push_data.status     = status;
        push_data.hash_total = (status == ST_OK) ? hashes_next : 6'd0;
        push_data.own_seen   = (status == ST_OK) ? own_next : 1'b0;
        push_valid = accept && (emit_hash || push_data.payload || end_of_frame);
    end

    // Hold state between bytes; clear it after the last byte of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CODE;
            pos_reg     <= '0;
            skip_reg    <= 3'd0;
            esize_reg   <= 3'd1;
            hops_reg    <= 6'd0;
            hop_idx_reg <= 6'd0;
            bie_reg     <= 2'd0;
            hashes_reg  <= 6'd0;
            own_reg     <= 1'b0;
            err_reg     <= ST_OK;
        end
        else if (accept)
        begin
            if (end_of_frame)
            begin
                phase_reg   <= PH_CODE;
                pos_reg     <= '0;
                skip_reg    <= 3'd0;
                esize_reg   <= 3'd1;
                hops_reg    <= 6'd0;
                hop_idx_reg <= 6'd0;
                bie_reg     <= 2'd0;
                hashes_reg  <= 6'd0;
                own_reg     <= 1'b0;
                err_reg     <= ST_OK;
            end
            else
            begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                skip_reg    <= skip_next;
                esize_reg   <= esize_next;
                hops_reg    <= hops_next;
                hop_idx_reg <= hop_idx_next;
                bie_reg     <= bie_next;
                hashes_reg  <= hashes_next;
                own_reg     <= own_next;
                err_reg     <= err_next;
            end
        end
    end

endmodule

// ----- rtl/mrfp_queue.sv -----
`timescale 1ns / 1ps
// Small command queue that decouples the parser from the back end.
// Uses mrfp_pkg for the command type and depth.
module mrfp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  mrfp_pkg::cmd_t  push_data,
    output logic            pop_valid,
    input  logic            pop,
    output mrfp_pkg::cmd_t  pop_data
);
    import mrfp_pkg::*;

    cmd_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/mrfp_back.sv -----
`timescale 1ns / 1ps
// Back end: folds payload bytes into the FNV-1a digest and drives the
// registered result stage. Uses mrfp_pkg.
module mrfp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop,
    input  mrfp_pkg::cmd_t  cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output mrfp_pkg::res_t  res
);
    import mrfp_pkg::*;

    logic [31:0] acc_reg;
    logic        hash_done_reg;
    logic        out_valid_reg;
    res_t        res_reg;

    logic [31:0] acc_mix;
    logic [31:0] acc_prod;
    logic [31:0] acc_step;
    logic [31:0] digest;
    logic        need_hash;
    logic        need_out;
    logic        can_load;
    logic        fire;

    // One FNV-1a step per payload byte
    assign acc_mix  = acc_reg ^ {24'd0, cmd.data};
    assign acc_prod = acc_mix * FNV_PRIME;
    assign acc_step = cmd.payload ? acc_prod : acc_reg;
    assign digest   = (cmd.status != ST_OK) ? 32'd0
                    : ((acc_step == 32'd0) ? 32'd1 : acc_step);

    // A byte with a hash and an end of frame takes two result slots
    assign need_hash = cmd.emit_hash && !hash_done_reg;
    assign need_out  = need_hash || cmd.eof;
    assign can_load  = !out_valid_reg || out_ready;
    assign fire      = pop_valid && (!need_out || can_load);
    assign pop       = fire && !(need_hash && cmd.eof);

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // Control: digest, split flag, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= FNV_BASIS;
            hash_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (need_hash)
                begin
                    hash_done_reg <= cmd.eof;
                end
                else
                begin
                    hash_done_reg <= 1'b0;
                    acc_reg       <= cmd.eof ? FNV_BASIS : acc_step;
                end
            end
            if (fire && need_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (fire && need_out)
        begin
            if (need_hash)
            begin
                res_reg.result_kind    <= KIND_HASH;
                res_reg.path_hash      <= cmd.data;
                res_reg.hash_total     <= 6'd0;
                res_reg.payload_digest <= 32'd0;
                res_reg.own_in_path    <= 1'b0;
                res_reg.status         <= ST_OK;
                res_reg.last_of_run    <= 1'b0;
            end
            else
            begin
                res_reg.result_kind    <= KIND_SUMMARY;
                res_reg.path_hash      <= 8'd0;
                res_reg.hash_total     <= cmd.hash_total;
                res_reg.payload_digest <= digest;
                res_reg.own_in_path    <= cmd.own_seen;
                res_reg.status         <= cmd.status;
                res_reg.last_of_run    <= 1'b1;
            end
        end
    end

endmodule
